@@ hw/rtl/aec_pkg.sv @@
// shared types and constants for the affect ema classifier
// fixed-point format, operation and register codes, controller commands
// no dependencies
`timescale 1ns / 1ps

package aec_pkg;

    // fixed-point format of the input signals, state values and configuration
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE / 2;
    localparam int K_SERO    = ((3 << FRAC_BITS) + 5) / 10;

    // field widths
    localparam int SIG_W     = 16;
    localparam int UNS_W     = 15;
    localparam int SQ_W      = 30;
    localparam int CAT_W     = 3;
    localparam int STEP_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // shared multiplier
    localparam int OPND_W    = 18;
    localparam int PROD_W    = 2 * OPND_W;

    // intensity below 0.3 is neutral
    localparam logic [SQ_W-1:0] NEUTRAL_SQ =
        SQ_W'(((64'd9 << (2 * FRAC_BITS)) + 64'd99) / 64'd100);

    // configuration reset values
    localparam int RST_ALPHA    = 14746;
    localparam int RST_PLEASANT = 4915;
    localparam int RST_EXCITED  = 8192;
    localparam int RST_NOVEL    = 8192;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_DECAY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA_VAL      = 3'd0,
        REG_ALPHA_ARO      = 3'd1,
        REG_ALPHA_NOV      = 3'd2,
        REG_PLEASANT_LEVEL = 3'd3,
        REG_UNPLEAS_LEVEL  = 3'd4,
        REG_EXCITED_LEVEL  = 3'd5,
        REG_NOVEL_LEVEL    = 3'd6
    } cfg_reg_t;

    typedef enum logic [CAT_W-1:0] {
        CAT_NEUTRAL      = 3'd0,
        CAT_PLEAS_EXCITE = 3'd1,
        CAT_PLEAS_CALM   = 3'd2,
        CAT_UNPL_EXCITE  = 3'd3,
        CAT_UNPL_CALM    = 3'd4
    } category_t;

    typedef enum logic [1:0] {
        CH_VAL = 2'd0,
        CH_ARO = 2'd1,
        CH_NOV = 2'd2
    } chan_t;

    typedef enum logic [1:0] {
        MUL_OLD    = 2'd0,
        MUL_DRIVE  = 2'd1,
        MUL_SERO   = 2'd2,
        MUL_SQUARE = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_LOAD  = 2'd1,
        ACC_ADD   = 2'd2,
        ACC_CLEAR = 2'd3
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_WB,
        ST_SERO_MUL,
        ST_SERO_WB,
        ST_SQ,
        ST_SQ_END,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     load_in;
        chan_t    ch;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     wb_state;
        logic     cnt_inc;
        logic     clear_state;
        logic     sero_wb;
        logic     out_load;
    } aec_cmd_t;

endpackage

@@ hw/rtl/affect_ema_classifier.sv @@
// top level of the affect ema classifier
// joins the sequencing controller and the datapath
// depends on aec_pkg, aec_ctrl, aec_datapath
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        sink       in_valid / in_ready       operation, reward, pred_error, ctx_novelty
// out       source     out_valid / out_ready     valence_out .. step_count
// cfg       sink       cfg_we                    cfg_index, cfg_data
//
// one item at a time through a single shared 18x18 multiplier
// the multiplier forms two products per integrator, one for serotonin, three squares
// reset clears the integrators, the update count, the output valid and loads config defaults
// a waiting result does not block the next input transfer; the controller
// only stalls in its final step while the output register is still full

module affect_ema_classifier #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [aec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aec_pkg::CFG_W-1:0]           cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic signed [aec_pkg::SIG_W-1:0]    reward,
    input  logic signed [aec_pkg::SIG_W-1:0]    pred_error,
    input  logic signed [aec_pkg::SIG_W-1:0]    ctx_novelty,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [aec_pkg::SIG_W-1:0]    valence_out,
    output logic [aec_pkg::UNS_W-1:0]           arousal_out,
    output logic [aec_pkg::UNS_W-1:0]           novelty_out,
    output logic [aec_pkg::UNS_W-1:0]           serotonin_out,
    output logic [aec_pkg::SQ_W-1:0]            intensity_sq,
    output logic [aec_pkg::CAT_W-1:0]           category,
    output logic                                pleasant_flag,
    output logic                                unpleasant_flag,
    output logic                                is_excited,
    output logic                                novel_flag,
    output logic [aec_pkg::STEP_W-1:0]          step_count
);

    // per-cycle command from the controller to the datapath
    aec_pkg::aec_cmd_t cmd;

    aec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (operation),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // holds config, integrators, multiplier, accumulator and output register
    aec_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .reward          (reward),
        .pred_error      (pred_error),
        .ctx_novelty     (ctx_novelty),
        .valence_out     (valence_out),
        .arousal_out     (arousal_out),
        .novelty_out     (novelty_out),
        .serotonin_out   (serotonin_out),
        .intensity_sq    (intensity_sq),
        .category        (category),
        .pleasant_flag   (pleasant_flag),
        .unpleasant_flag (unpleasant_flag),
        .is_excited      (is_excited),
        .novel_flag      (novel_flag),
        .step_count      (step_count)
    );

`ifndef SYNTHESIS
    // one item in flight: no second input transfer right after one
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an input transfer");

    // the integrators stay inside their clamp ranges
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(valence_out) <= aec_pkg::ONE &&
                       $signed(valence_out) >= -aec_pkg::ONE &&
                       arousal_out <= aec_pkg::UNS_W'(aec_pkg::ONE) &&
                       novelty_out <= aec_pkg::UNS_W'(aec_pkg::ONE)))
        else $error("state value outside its range");

    // neutral category exactly when the intensity is below threshold
    a_neutral_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((category == aec_pkg::CAT_NEUTRAL) ==
                       (intensity_sq < aec_pkg::NEUTRAL_SQ)))
        else $error("neutral category disagrees with intensity");

    // non-neutral categories agree with the pleasant and excited flags
    a_category_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && category != aec_pkg::CAT_NEUTRAL) |->
            (((category == aec_pkg::CAT_PLEAS_EXCITE) ||
              (category == aec_pkg::CAT_PLEAS_CALM)) == pleasant_flag) &&
            (((category == aec_pkg::CAT_PLEAS_EXCITE) ||
              (category == aec_pkg::CAT_UNPL_EXCITE)) == is_excited))
        else $error("category disagrees with flags");
`endif

endmodule

@@ hw/rtl/aec_ctrl.sv @@
// sequencing state machine for the affect ema classifier
// walks the shared multiplier through blend, serotonin and intensity steps
// depends on aec_pkg
`timescale 1ns / 1ps

module aec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_op,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output aec_pkg::aec_cmd_t   cmd
);

    aec_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    aec_pkg::chan_t       ch_reg, ch_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aec_pkg::ST_IDLE;
            op_reg        <= aec_pkg::OP_UPDATE;
            ch_reg        <= aec_pkg::CH_VAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ch_next    = ch_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;

        case (state_reg)
            aec_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = in_op;
                    ch_next     = aec_pkg::CH_VAL;
                    case (in_op)
                        aec_pkg::OP_UPDATE,
                        aec_pkg::OP_DECAY:  state_next = aec_pkg::ST_MUL0;
                        aec_pkg::OP_CLEAR:  state_next = aec_pkg::ST_CLEAR;
                        default:            state_next = aec_pkg::ST_SERO_MUL;
                    endcase
                end
            end
            aec_pkg::ST_CLEAR:
            begin
                cmd.clear_state = 1'b1;
                state_next      = aec_pkg::ST_SERO_MUL;
            end
            aec_pkg::ST_MUL0:
            begin
                cmd.mul_sel = aec_pkg::MUL_OLD;
                state_next  = aec_pkg::ST_MUL1;
            end
            aec_pkg::ST_MUL1:
            begin
                // decay keeps only alpha*old
                cmd.mul_sel = aec_pkg::MUL_DRIVE;
                cmd.acc_op  = aec_pkg::ACC_LOAD;
                state_next  = (op_reg == aec_pkg::OP_DECAY) ? aec_pkg::ST_WB
                                                            : aec_pkg::ST_SUM;
            end
            aec_pkg::ST_SUM:
            begin
                cmd.acc_op = aec_pkg::ACC_ADD;
                state_next = aec_pkg::ST_WB;
            end
            aec_pkg::ST_WB:
            begin
                cmd.wb_state = 1'b1;
                if (ch_reg == aec_pkg::CH_NOV)
                begin
                    cmd.cnt_inc = (op_reg == aec_pkg::OP_UPDATE);
                    state_next  = aec_pkg::ST_SERO_MUL;
                end
                else
                begin
                    ch_next    = aec_pkg::chan_t'(ch_reg + 2'd1);
                    state_next = aec_pkg::ST_MUL0;
                end
            end
            aec_pkg::ST_SERO_MUL:
            begin
                cmd.mul_sel = aec_pkg::MUL_SERO;
                state_next  = aec_pkg::ST_SERO_WB;
            end
            aec_pkg::ST_SERO_WB:
            begin
                cmd.sero_wb = 1'b1;
                cmd.acc_op  = aec_pkg::ACC_CLEAR;
                ch_next     = aec_pkg::CH_VAL;
                state_next  = aec_pkg::ST_SQ;
            end
            aec_pkg::ST_SQ:
            begin
                cmd.mul_sel = aec_pkg::MUL_SQUARE;
                cmd.acc_op  = (ch_reg == aec_pkg::CH_VAL) ? aec_pkg::ACC_HOLD
                                                          : aec_pkg::ACC_ADD;
                if (ch_reg == aec_pkg::CH_NOV)
                    state_next = aec_pkg::ST_SQ_END;
                else
                    ch_next = aec_pkg::chan_t'(ch_reg + 2'd1);
            end
            aec_pkg::ST_SQ_END:
            begin
                cmd.acc_op = aec_pkg::ACC_ADD;
                state_next = aec_pkg::ST_OUT;
            end
            aec_pkg::ST_OUT:
            begin
                // wait until the output register is free or being emptied
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = aec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aec_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/aec_datapath.sv @@
// datapath of the affect ema classifier
// config registers, integrators, one shared multiplier, accumulator, outputs
// depends on aec_pkg
`timescale 1ns / 1ps

module aec_datapath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  aec_pkg::aec_cmd_t                   cmd,
    input  logic                                cfg_we,
    input  logic [aec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aec_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [aec_pkg::SIG_W-1:0]    reward,
    input  logic signed [aec_pkg::SIG_W-1:0]    pred_error,
    input  logic signed [aec_pkg::SIG_W-1:0]    ctx_novelty,
    output logic signed [aec_pkg::SIG_W-1:0]    valence_out,
    output logic [aec_pkg::UNS_W-1:0]           arousal_out,
    output logic [aec_pkg::UNS_W-1:0]           novelty_out,
    output logic [aec_pkg::UNS_W-1:0]           serotonin_out,
    output logic [aec_pkg::SQ_W-1:0]            intensity_sq,
    output logic [aec_pkg::CAT_W-1:0]           category,
    output logic                                pleasant_flag,
    output logic                                unpleasant_flag,
    output logic                                is_excited,
    output logic                                novel_flag,
    output logic [aec_pkg::STEP_W-1:0]          step_count
);

    localparam int SIG_W  = aec_pkg::SIG_W;
    localparam int UNS_W  = aec_pkg::UNS_W;
    localparam int OPND_W = aec_pkg::OPND_W;
    localparam int PROD_W = aec_pkg::PROD_W;

    // configuration
    logic [UNS_W-1:0]        alpha_val_reg, alpha_aro_reg, alpha_nov_reg;
    logic signed [SIG_W-1:0] pleasant_reg, unpleas_reg;
    logic [UNS_W-1:0]        excited_reg, novel_reg;

    // integrators and count
    logic signed [SIG_W-1:0] val_reg;
    logic [UNS_W-1:0]        aro_reg, nov_reg;
    logic [COUNT_WIDTH-1:0]  cnt_reg;

    // captured item
    logic signed [SIG_W-1:0] rew_reg, perr_reg, ctx_reg;

    // arithmetic
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic [UNS_W-1:0]         sero_reg;

    logic [UNS_W-1:0]         alpha_raw, alpha_sat, alpha_inv;
    logic signed [OPND_W-1:0] old_val, drive_val, sero_diff;
    logic signed [OPND_W-1:0] opnd_a, opnd_b;
    logic signed [SIG_W:0]    perr_ext, perr_mag;
    logic signed [PROD_W-1:0] acc_shr, sero_sum;
    logic signed [SIG_W-1:0]  val_wb;
    logic [UNS_W-1:0]         uns_wb, sero_clamped;
    logic [63:0]              cnt_wide;
    logic                     pl_flag, ex_flag;
    aec_pkg::category_t       cat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_val_reg <= UNS_W'(aec_pkg::RST_ALPHA);
            alpha_aro_reg <= UNS_W'(aec_pkg::RST_ALPHA);
            alpha_nov_reg <= UNS_W'(aec_pkg::RST_ALPHA);
            pleasant_reg  <= SIG_W'(aec_pkg::RST_PLEASANT);
            unpleas_reg   <= SIG_W'(-aec_pkg::RST_PLEASANT);
            excited_reg   <= UNS_W'(aec_pkg::RST_EXCITED);
            novel_reg     <= UNS_W'(aec_pkg::RST_NOVEL);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aec_pkg::REG_ALPHA_VAL:      alpha_val_reg <= cfg_data[UNS_W-1:0];
                aec_pkg::REG_ALPHA_ARO:      alpha_aro_reg <= cfg_data[UNS_W-1:0];
                aec_pkg::REG_ALPHA_NOV:      alpha_nov_reg <= cfg_data[UNS_W-1:0];
                aec_pkg::REG_PLEASANT_LEVEL: pleasant_reg  <= cfg_data;
                aec_pkg::REG_UNPLEAS_LEVEL:  unpleas_reg   <= cfg_data;
                aec_pkg::REG_EXCITED_LEVEL:  excited_reg   <= cfg_data[UNS_W-1:0];
                aec_pkg::REG_NOVEL_LEVEL:    novel_reg     <= cfg_data[UNS_W-1:0];
                default:                     ;
            endcase
        end
    end

    // operand selection
    always_comb
    begin
        case (cmd.ch)
            aec_pkg::CH_VAL: alpha_raw = alpha_val_reg;
            aec_pkg::CH_ARO: alpha_raw = alpha_aro_reg;
            default:         alpha_raw = alpha_nov_reg;
        endcase
        // alpha above one acts as one
        alpha_sat = (alpha_raw > UNS_W'(aec_pkg::ONE)) ? UNS_W'(aec_pkg::ONE) : alpha_raw;
        alpha_inv = UNS_W'(aec_pkg::ONE) - alpha_sat;

        perr_ext = (SIG_W + 1)'(perr_reg);
        perr_mag = perr_ext[SIG_W] ? -perr_ext : perr_ext;

        case (cmd.ch)
            aec_pkg::CH_VAL:
            begin
                old_val   = OPND_W'(val_reg);
                drive_val = OPND_W'(rew_reg);
            end
            aec_pkg::CH_ARO:
            begin
                old_val   = OPND_W'(aro_reg);
                drive_val = OPND_W'(perr_mag);
            end
            default:
            begin
                old_val   = OPND_W'(nov_reg);
                drive_val = OPND_W'(ctx_reg);
            end
        endcase

        sero_diff = OPND_W'(val_reg) - OPND_W'(aro_reg);

        case (cmd.mul_sel)
            aec_pkg::MUL_OLD:
            begin
                opnd_a = OPND_W'(alpha_sat);
                opnd_b = old_val;
            end
            aec_pkg::MUL_DRIVE:
            begin
                opnd_a = OPND_W'(alpha_inv);
                opnd_b = drive_val;
            end
            aec_pkg::MUL_SERO:
            begin
                opnd_a = OPND_W'(aec_pkg::K_SERO);
                opnd_b = sero_diff;
            end
            default:
            begin
                opnd_a = old_val;
                opnd_b = old_val;
            end
        endcase
    end

    // floor of the sum, clamped to the channel range; serotonin plus half
    always_comb
    begin
        acc_shr = acc_reg >>> aec_pkg::FRAC_BITS;

        if (acc_shr > PROD_W'(aec_pkg::ONE))
            val_wb = SIG_W'(aec_pkg::ONE);
        else if (acc_shr < PROD_W'(-aec_pkg::ONE))
            val_wb = SIG_W'(-aec_pkg::ONE);
        else
            val_wb = acc_shr[SIG_W-1:0];

        if (acc_shr < PROD_W'(0))
            uns_wb = '0;
        else if (acc_shr > PROD_W'(aec_pkg::ONE))
            uns_wb = UNS_W'(aec_pkg::ONE);
        else
            uns_wb = acc_shr[UNS_W-1:0];

        sero_sum = (prod_reg >>> aec_pkg::FRAC_BITS) + PROD_W'(aec_pkg::HALF);
        if (sero_sum < PROD_W'(0))
            sero_clamped = '0;
        else if (sero_sum > PROD_W'(aec_pkg::ONE))
            sero_clamped = UNS_W'(aec_pkg::ONE);
        else
            sero_clamped = sero_sum[UNS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opnd_a * opnd_b;
        case (cmd.acc_op)
            aec_pkg::ACC_LOAD:  acc_reg <= prod_reg;
            aec_pkg::ACC_ADD:   acc_reg <= acc_reg + prod_reg;
            aec_pkg::ACC_CLEAR: acc_reg <= '0;
            default:            acc_reg <= acc_reg;
        endcase
        if (cmd.load_in)
        begin
            rew_reg  <= reward;
            perr_reg <= pred_error;
            ctx_reg  <= ctx_novelty;
        end
        if (cmd.sero_wb)
            sero_reg <= sero_clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            aro_reg <= '0;
            nov_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.clear_state)
        begin
            val_reg <= '0;
            aro_reg <= '0;
            nov_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.wb_state)
            begin
                case (cmd.ch)
                    aec_pkg::CH_VAL: val_reg <= val_wb;
                    aec_pkg::CH_ARO: aro_reg <= uns_wb;
                    default:         nov_reg <= uns_wb;
                endcase
            end
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + COUNT_WIDTH'(1);
        end
    end

    // result fields
    always_comb
    begin
        pl_flag = (val_reg > pleasant_reg);
        ex_flag = (aro_reg > excited_reg);
        if (acc_reg[aec_pkg::SQ_W-1:0] < aec_pkg::NEUTRAL_SQ)
            cat_next = aec_pkg::CAT_NEUTRAL;
        else if (pl_flag)
            cat_next = ex_flag ? aec_pkg::CAT_PLEAS_EXCITE : aec_pkg::CAT_PLEAS_CALM;
        else
            cat_next = ex_flag ? aec_pkg::CAT_UNPL_EXCITE : aec_pkg::CAT_UNPL_CALM;
        cnt_wide = 64'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            valence_out     <= val_reg;
            arousal_out     <= aro_reg;
            novelty_out     <= nov_reg;
            serotonin_out   <= sero_reg;
            intensity_sq    <= acc_reg[aec_pkg::SQ_W-1:0];
            category        <= cat_next;
            pleasant_flag   <= pl_flag;
            unpleasant_flag <= (val_reg < unpleas_reg);
            is_excited      <= ex_flag;
            novel_flag      <= (nov_reg > novel_reg);
            step_count      <= cnt_wide[aec_pkg::STEP_W-1:0];
        end
    end

endmodule
